FILE: rtl/core/dapc_pkg.sv
// Package: formats, limits, register indexes and reset values for the dual-axis PID controller.
package dapc_pkg;

  // Axis count and axis indexes
  localparam int NUM_AXES   = 2;
  localparam int AXIS_YAW   = 0;
  localparam int AXIS_PITCH = 1;

  // Limits (Q8.7 units)
  localparam int INTEGRAL_LIMIT  = 12800;
  localparam int OUTPUT_LIMIT    = 1280;
  localparam int DRIVE_FIELD_MAX = 2047;
  localparam int DRIVE_LIMIT     = (OUTPUT_LIMIT > DRIVE_FIELD_MAX) ? DRIVE_FIELD_MAX
                                                                    : OUTPUT_LIMIT;

  // Gain shift for unsigned Q4.12
  localparam int GAIN_FRAC = 12;

  // Data types
  typedef logic signed [15:0] angle_t;
  typedef logic signed [16:0] err_t;
  typedef logic signed [17:0] dif_t;
  typedef logic signed [14:0] integ_t;
  typedef logic        [15:0] gain_t;
  typedef logic signed [11:0] drive_t;
  typedef logic        [2:0]  reg_idx_t;

  // Action codes (request tuser)
  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Register indexes
  localparam reg_idx_t REG_YAW_KP   = 3'd0;
  localparam reg_idx_t REG_YAW_KI   = 3'd1;
  localparam reg_idx_t REG_YAW_KD   = 3'd2;
  localparam reg_idx_t REG_PITCH_KP = 3'd3;
  localparam reg_idx_t REG_PITCH_KI = 3'd4;
  localparam reg_idx_t REG_PITCH_KD = 3'd5;

  // Gain reset values
  localparam gain_t KP_RESET = 16'd2048;
  localparam gain_t KI_RESET = 16'd41;
  localparam gain_t KD_RESET = 16'd410;

endpackage

FILE: rtl/core/dual_axis_pid_controller_top.sv
// Top level: dual-axis positional PID controller with integral clamp, four-register pipeline.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  in_     | slave     | goal_yaw, goal_pitch, meas_yaw, meas_pitch  | action
//  out_    | master    | drive_yaw, drive_pitch                      | -
//  cfg_    | write     | cfg_wdata: gain value, cfg_addr: reg index  | -
//
// One request per cycle sustained while out_tready is high; each request passes through the
// input register, the error/integral register with the loop state, the product
// register and the result register. The loop state updates as a request leaves
// the input register. Reset restores default gains, zeroes integrals and previous
// errors and empties the pipeline. With out_tready low, bubbles close up and in_tready
// drops only once all four registers hold requests.
module dual_axis_pid_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // goal_yaw, goal_pitch, measured_yaw, measured_pitch
  input  logic [0:0]  in_tuser,   // action
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // drive_yaw, drive_pitch
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int NA = dapc_pkg::NUM_AXES;

  // Gain registers
  dapc_pkg::gain_t kp_r [NA];
  dapc_pkg::gain_t ki_r [NA];
  dapc_pkg::gain_t kd_r [NA];

  // Loop state
  dapc_pkg::integ_t integ_r [NA];
  dapc_pkg::err_t   prev_r  [NA];

  // Stage 1: input register
  logic             v1_r;
  logic             clr1_r;
  dapc_pkg::angle_t tgt1_r  [NA];
  dapc_pkg::angle_t meas1_r [NA];

  // Stage 2: error, integral, difference
  logic              v2_r;
  logic              clr2_r;
  dapc_pkg::err_t    err2_r [NA];
  dapc_pkg::integ_t  acc2_r [NA];
  dapc_pkg::dif_t    dif2_r [NA];

  // Stage 3: products
  logic                v3_r;
  logic                clr3_r;
  logic signed [33:0]  pp3_r [NA];
  logic signed [31:0]  pi3_r [NA];
  logic signed [34:0]  pd3_r [NA];

  // Result register
  logic             vo_r;
  dapc_pkg::drive_t drv_r [NA];

  // Stage enables
  logic en1, en2, en3, eno;

  // Combinational values
  dapc_pkg::err_t   err_c   [NA];
  dapc_pkg::integ_t acc_c   [NA];
  dapc_pkg::dif_t   dif_c   [NA];
  logic signed [33:0] pp_c  [NA];
  logic signed [31:0] pi_c  [NA];
  logic signed [34:0] pd_c  [NA];
  dapc_pkg::drive_t drv_c   [NA];

  // Advance a stage when its successor is empty or moving
  assign eno = !vo_r || out_tready;
  assign en3 = !v3_r || eno;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  assign out_tvalid = vo_r;
  assign out_tdata  = {drv_r[dapc_pkg::AXIS_PITCH], drv_r[dapc_pkg::AXIS_YAW]};

  // Gain writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        kp_r[a] <= dapc_pkg::KP_RESET;
        ki_r[a] <= dapc_pkg::KI_RESET;
        kd_r[a] <= dapc_pkg::KD_RESET;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        dapc_pkg::REG_YAW_KP:   kp_r[dapc_pkg::AXIS_YAW]   <= cfg_wdata;
        dapc_pkg::REG_YAW_KI:   ki_r[dapc_pkg::AXIS_YAW]   <= cfg_wdata;
        dapc_pkg::REG_YAW_KD:   kd_r[dapc_pkg::AXIS_YAW]   <= cfg_wdata;
        dapc_pkg::REG_PITCH_KP: kp_r[dapc_pkg::AXIS_PITCH] <= cfg_wdata;
        dapc_pkg::REG_PITCH_KI: ki_r[dapc_pkg::AXIS_PITCH] <= cfg_wdata;
        dapc_pkg::REG_PITCH_KD: kd_r[dapc_pkg::AXIS_PITCH] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Error, clamped integral and difference per axis
  always_comb begin
    logic signed [17:0] sum_i;
    for (int a = 0; a < NA; a++) begin
      err_c[a] = 17'(tgt1_r[a]) - 17'(meas1_r[a]);
      sum_i    = 18'(integ_r[a]) + 18'(err_c[a]);
      if (sum_i > dapc_pkg::INTEGRAL_LIMIT) begin
        acc_c[a] = 15'(dapc_pkg::INTEGRAL_LIMIT);
      end else if (sum_i < -dapc_pkg::INTEGRAL_LIMIT) begin
        acc_c[a] = 15'(-dapc_pkg::INTEGRAL_LIMIT);
      end else begin
        acc_c[a] = sum_i[14:0];
      end
      dif_c[a] = 18'(err_c[a]) - 18'(prev_r[a]);
    end
  end

  // Gain products per axis
  always_comb begin
    logic signed [16:0] kps, kis, kds;
    for (int a = 0; a < NA; a++) begin
      kps = signed'({1'b0, kp_r[a]});
      kis = signed'({1'b0, ki_r[a]});
      kds = signed'({1'b0, kd_r[a]});
      pp_c[a] = 34'(kps) * 34'(err2_r[a]);
      pi_c[a] = 32'(kis) * 32'(acc2_r[a]);
      pd_c[a] = 35'(kds) * 35'(dif2_r[a]);
    end
  end

  // Floor-shift terms, sum and clamp per axis; a clear request gives zero drives
  always_comb begin
    logic signed [21:0] tp;
    logic signed [19:0] ti;
    logic signed [22:0] td;
    logic signed [23:0] sum_d;
    for (int a = 0; a < NA; a++) begin
      tp    = $signed(pp3_r[a][33:dapc_pkg::GAIN_FRAC]);
      ti    = $signed(pi3_r[a][31:dapc_pkg::GAIN_FRAC]);
      td    = $signed(pd3_r[a][34:dapc_pkg::GAIN_FRAC]);
      sum_d = 24'(tp) + 24'(ti) + 24'(td);
      if (clr3_r) begin
        drv_c[a] = '0;
      end else if (sum_d > dapc_pkg::DRIVE_LIMIT) begin
        drv_c[a] = 12'(dapc_pkg::DRIVE_LIMIT);
      end else if (sum_d < -dapc_pkg::DRIVE_LIMIT) begin
        drv_c[a] = 12'(-dapc_pkg::DRIVE_LIMIT);
      end else begin
        drv_c[a] = sum_d[11:0];
      end
    end
  end

  // Pipeline valid bits and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        integ_r[a] <= '0;
        prev_r[a]  <= '0;
      end
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (eno) vo_r <= v3_r;
      // Commit state as a request leaves the input register
      if (en2 && v1_r) begin
        for (int a = 0; a < NA; a++) begin
          if (clr1_r) begin
            integ_r[a] <= '0;
            prev_r[a]  <= '0;
          end else begin
            integ_r[a] <= acc_c[a];
            prev_r[a]  <= err_c[a];
          end
        end
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en1) begin
      clr1_r <= (in_tuser[0] == dapc_pkg::ACT_CLEAR);
      tgt1_r[dapc_pkg::AXIS_YAW]    <= in_tdata[15:0];
      tgt1_r[dapc_pkg::AXIS_PITCH]  <= in_tdata[31:16];
      meas1_r[dapc_pkg::AXIS_YAW]   <= in_tdata[47:32];
      meas1_r[dapc_pkg::AXIS_PITCH] <= in_tdata[63:48];
    end
    if (en2) begin
      clr2_r <= clr1_r;
      for (int a = 0; a < NA; a++) begin
        err2_r[a] <= err_c[a];
        acc2_r[a] <= acc_c[a];
        dif2_r[a] <= dif_c[a];
      end
    end
    if (en3) begin
      clr3_r <= clr2_r;
      for (int a = 0; a < NA; a++) begin
        pp3_r[a] <= pp_c[a];
        pi3_r[a] <= pi_c[a];
        pd3_r[a] <= pd_c[a];
      end
    end
    if (eno) begin
      for (int a = 0; a < NA; a++) begin
        drv_r[a] <= drv_c[a];
      end
    end
  end

`ifndef ASSERT_OFF
  // Integrals stay inside their clamp
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r[dapc_pkg::AXIS_YAW] <= dapc_pkg::INTEGRAL_LIMIT) &&
    (integ_r[dapc_pkg::AXIS_YAW] >= -dapc_pkg::INTEGRAL_LIMIT) &&
    (integ_r[dapc_pkg::AXIS_PITCH] <= dapc_pkg::INTEGRAL_LIMIT) &&
    (integ_r[dapc_pkg::AXIS_PITCH] >= -dapc_pkg::INTEGRAL_LIMIT))
    else $error("integral out of clamp range");

  // Presented drives stay inside the output limit
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> (drv_r[dapc_pkg::AXIS_YAW] <= dapc_pkg::DRIVE_LIMIT) &&
             (drv_r[dapc_pkg::AXIS_YAW] >= -dapc_pkg::DRIVE_LIMIT) &&
             (drv_r[dapc_pkg::AXIS_PITCH] <= dapc_pkg::DRIVE_LIMIT) &&
             (drv_r[dapc_pkg::AXIS_PITCH] >= -dapc_pkg::DRIVE_LIMIT))
    else $error("drive out of limit");

  // A clear request leaves zero loop state behind
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (en2 && v1_r && clr1_r) |=>
      (integ_r[dapc_pkg::AXIS_YAW] == '0) && (integ_r[dapc_pkg::AXIS_PITCH] == '0) &&
      (prev_r[dapc_pkg::AXIS_YAW] == '0) && (prev_r[dapc_pkg::AXIS_PITCH] == '0))
    else $error("clear did not zero loop state");

  // Input backpressure only with a full, stalled pipeline
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && vo_r && !out_tready))
    else $error("input stalled with room in pipeline");

  // A clear request reaches the output as zero drives
  a_clear_out: assert property (@(posedge clk) disable iff (!rst_n)
    (eno && v3_r && clr3_r) |=> (out_tdata == '0))
    else $error("clear produced nonzero drive");
`endif

endmodule
